[rtl/dpod_pkg.sv]
`default_nettype none

package dpod_pkg;

    // Request: two date periods, each a start and an end date
    typedef struct packed {
        logic [4:0]  first_start_day;
        logic [3:0]  first_start_month;
        logic [13:0] first_start_year;
        logic [4:0]  first_end_day;
        logic [3:0]  first_end_month;
        logic [13:0] first_end_year;
        logic [4:0]  second_start_day;
        logic [3:0]  second_start_month;
        logic [13:0] second_start_year;
        logic [4:0]  second_end_day;
        logic [3:0]  second_end_month;
        logic [13:0] second_end_year;
    } req_t;

    // Result: overlap count and bad-date flag
    typedef struct packed {
        logic [21:0] overlap_days;
        logic        invalid_date;
    } rsp_t;

    // Per-stage load enables, stage 1 nearest the request side
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    localparam int NUM_DATES = 4;

    // Day-number arithmetic widths
    localparam int YY_W  = 15;   // shifted year, up to 16383 + 400
    localparam int DN_W  = 23;   // day number
    localparam int CNT_W = 22;   // result count

    localparam logic [YY_W-1:0]  YEAR_OFFSET   = 15'd400;
    localparam logic [12:0]      DIV100_MUL    = 13'd5243;  // ceil(2^19 / 100)
    localparam int               DIV100_SHIFT  = 19;
    localparam logic [8:0]       DAYS_PER_YEAR = 9'd365;
    localparam logic [CNT_W-1:0] COUNT_MAX     = 22'd4194303;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Days in a month of a common year; zero for a month code that is no month
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1:    r = 5'd31;
            4'd2:    r = 5'd28;
            4'd3:    r = 5'd31;
            4'd4:    r = 5'd30;
            4'd5:    r = 5'd31;
            4'd6:    r = 5'd30;
            4'd7:    r = 5'd31;
            4'd8:    r = 5'd31;
            4'd9:    r = 5'd30;
            4'd10:   r = 5'd31;
            4'd11:   r = 5'd30;
            4'd12:   r = 5'd31;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Days before the month's first day, counting the year from March
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/dpod_date_conv.sv]
`default_nettype none

module dpod_date_conv
    import dpod_pkg::*;
(
    input  wire logic            clk,
    input  wire pipe_en_t        en,
    input  wire logic [4:0]      day,
    input  wire logic [3:0]      month,
    input  wire logic [13:0]     year,
    output logic      [DN_W-1:0] day_num,
    output logic                 date_ok
);

    // Stage 1: shifted year, reciprocal products for the /100 terms
    logic [YY_W-1:0] yy_a;
    logic [27:0]     prod_yy_a;
    logic [25:0]     prod_yy4_a;
    logic [26:0]     prod_y_a;

    always_comb
    begin
        yy_a       = YY_W'(year) + YEAR_OFFSET
                     - ((month <= MONTH_FEB) ? YY_W'(1) : YY_W'(0));
        prod_yy_a  = 28'(yy_a) * 28'(DIV100_MUL);
        prod_yy4_a = 26'(yy_a[YY_W-1:2]) * 26'(DIV100_MUL);
        prod_y_a   = 27'(year) * 27'(DIV100_MUL);
    end

    logic [YY_W-1:0] yy_reg;
    logic [27:0]     prod_yy_reg;
    logic [25:0]     prod_yy4_reg;
    logic [26:0]     prod_y_reg;
    logic [13:0]     year_reg;
    logic [4:0]      day_reg;
    logic [3:0]      month_reg;
    logic [8:0]      mstart_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            yy_reg       <= yy_a;
            prod_yy_reg  <= prod_yy_a;
            prod_yy4_reg <= prod_yy4_a;
            prod_y_reg   <= prod_y_a;
            year_reg     <= year;
            day_reg      <= day;
            month_reg    <= month;
            mstart_reg   <= month_start(month);
        end
    end

    // Stage 2: year part of the day number, leap rule, date check
    logic [8:0]      q100_b;
    logic [6:0]      q400_b;
    logic [7:0]      yq_b;
    logic [DN_W-1:0] ypart_b;
    logic [9:0]      mpart_b;
    logic            y100_b;
    logic            leap_b;
    logic [4:0]      lim_b;
    logic            ok_b;

    always_comb
    begin
        q100_b  = prod_yy_reg[27:DIV100_SHIFT];
        q400_b  = prod_yy4_reg[25:DIV100_SHIFT];
        yq_b    = prod_y_reg[26:DIV100_SHIFT];
        ypart_b = DN_W'(yy_reg) * DN_W'(DAYS_PER_YEAR)
                  + DN_W'(yy_reg[YY_W-1:2]) + DN_W'(q400_b);
        mpart_b = 10'(mstart_reg) + 10'(day_reg);
        // divisible by 100 when the quotient times 100 gives the year back
        y100_b  = (15'(year_reg) == 15'(yq_b) * 15'd100);
        leap_b  = ((year_reg[1:0] == 2'b00) && !y100_b)
                  || (y100_b && (yq_b[1:0] == 2'b00));
        if (month_reg == MONTH_FEB)
            lim_b = leap_b ? 5'd29 : 5'd28;
        else
            lim_b = month_len(month_reg);
        ok_b    = (month_reg != 4'd0) && (month_reg <= MONTH_DEC)
                  && (day_reg != 5'd0) && (day_reg <= lim_b);
    end

    logic [DN_W-1:0] ypart_reg;
    logic [9:0]      mpart_reg;
    logic [8:0]      q100_reg;
    logic            ok2_reg;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            ypart_reg <= ypart_b;
            mpart_reg <= mpart_b;
            q100_reg  <= q100_b;
            ok2_reg   <= ok_b;
        end
    end

    // Stage 3: final day number
    logic [DN_W-1:0] dn_reg;
    logic            ok3_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            dn_reg  <= ypart_reg + DN_W'(mpart_reg) - DN_W'(q100_reg) - DN_W'(1);
            ok3_reg <= ok2_reg;
        end
    end

    assign day_num = dn_reg;
    assign date_ok = ok3_reg;

endmodule

`default_nettype wire

[rtl/dpod_overlap.sv]
`default_nettype none

module dpod_overlap
    import dpod_pkg::*;
(
    input  wire logic      clk,
    input  wire pipe_en_t  en,
    input  wire logic [DN_W-1:0] dn0,
    input  wire logic [DN_W-1:0] dn1,
    input  wire logic [DN_W-1:0] dn2,
    input  wire logic [DN_W-1:0] dn3,
    input  wire logic [NUM_DATES-1:0] ok,
    output rsp_t           rsp
);

    // Stage 4: later start, earlier end, direction checks
    logic [DN_W-1:0] lo_reg;
    logic [DN_W-1:0] hi_reg;
    logic            fwd_reg;
    logic            bad_reg;

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            lo_reg  <= (dn0 > dn2) ? dn0 : dn2;
            hi_reg  <= (dn1 < dn3) ? dn1 : dn3;
            fwd_reg <= (dn0 <= dn1) && (dn2 <= dn3);
            bad_reg <= !(&ok);
        end
    end

    // Stage 5: inclusive span, saturated
    logic [DN_W-1:0]  span_e;
    logic [CNT_W-1:0] cnt_e;

    always_comb
    begin
        span_e = hi_reg - lo_reg + DN_W'(1);
        if (bad_reg || !fwd_reg || (lo_reg > hi_reg))
            cnt_e = '0;
        else if (span_e > DN_W'(COUNT_MAX))
            cnt_e = COUNT_MAX;
        else
            cnt_e = span_e[CNT_W-1:0];
    end

    rsp_t rsp_reg;

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            rsp_reg.overlap_days <= cnt_e;
            rsp_reg.invalid_date <= bad_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

[rtl/date_period_overlap_days_top.sv]
// Date period overlap day counter.
// Request channel (req_valid / req_ready / req) carries two date periods,
// each a start and an end date; the response channel (rsp_valid /
// rsp_ready / rsp) returns the number of calendar days common to both
// periods, ends included, and a flag set when any date is not a real
// Gregorian date (the count is then zero).
// Pipeline: five register stages, the last of them the response register that
// drives rsp_valid. Throughput: one request per cycle while the receiver
// does not stall; each date goes through three stages (year products, year
// and month terms, day number), then two stages form the overlap and the
// saturated count.
// Each stage holds a valid bit and loads when it is empty or its
// successor loads, so a stalled receiver fills the pipeline bubbles first
// and only then drops req_ready; nothing is lost or repeated.
// Reset clears every valid bit: the block comes out of reset empty and
// ready to take a request.
`default_nettype none

module date_period_overlap_days_top
    import dpod_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    // Valid bits per stage
    logic [5:1] vld_reg;
    logic [5:1] vld_next;
    pipe_en_t   en;

    // Ready chain from the output register backwards
    always_comb
    begin
        en.s5 = !vld_reg[5] || rsp_ready;
        en.s4 = !vld_reg[4] || en.s5;
        en.s3 = !vld_reg[3] || en.s4;
        en.s2 = !vld_reg[2] || en.s3;
        en.s1 = !vld_reg[1] || en.s2;
    end

    always_comb
    begin
        vld_next    = vld_reg;
        if (en.s1) vld_next[1] = req_valid;
        if (en.s2) vld_next[2] = vld_reg[1];
        if (en.s3) vld_next[3] = vld_reg[2];
        if (en.s4) vld_next[4] = vld_reg[3];
        if (en.s5) vld_next[5] = vld_reg[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign req_ready = en.s1;
    assign rsp_valid = vld_reg[5];

    // Date fields in period order
    logic [4:0]      day_a   [NUM_DATES];
    logic [3:0]      month_a [NUM_DATES];
    logic [13:0]     year_a  [NUM_DATES];
    logic [DN_W-1:0] dn      [NUM_DATES];
    logic [NUM_DATES-1:0] ok;

    always_comb
    begin
        day_a[0]   = req.first_start_day;
        month_a[0] = req.first_start_month;
        year_a[0]  = req.first_start_year;
        day_a[1]   = req.first_end_day;
        month_a[1] = req.first_end_month;
        year_a[1]  = req.first_end_year;
        day_a[2]   = req.second_start_day;
        month_a[2] = req.second_start_month;
        year_a[2]  = req.second_start_year;
        day_a[3]   = req.second_end_day;
        month_a[3] = req.second_end_month;
        year_a[3]  = req.second_end_year;
    end

    // One day-number pipeline per date
    for (genvar g = 0; g < NUM_DATES; g++)
    begin : g_conv
        dpod_date_conv u_conv
        (
            .clk     (clk),
            .en      (en),
            .day     (day_a[g]),
            .month   (month_a[g]),
            .year    (year_a[g]),
            .day_num (dn[g]),
            .date_ok (ok[g])
        );
    end

    dpod_overlap u_overlap
    (
        .clk (clk),
        .en  (en),
        .dn0 (dn[0]),
        .dn1 (dn[1]),
        .dn2 (dn[2]),
        .dn3 (dn[3]),
        .ok  (ok),
        .rsp (rsp)
    );

endmodule

`default_nettype wire
